// ===== rtl/core/pidaw_pkg.sv =====
// Shared constants and types for the PID axis block.
// Used by pidaw_div and pid_axis_antiwindup_dfilter; no dependencies.
package pidaw_pkg;

  // Angle (Q3.12) and error (Q4.12) widths
  localparam int ANGLE_W = 16;
  localparam int ERR_W   = 17;
  localparam int GAIN_W  = 16;
  localparam int SMOOTH_W = 17;
  localparam int LIMIT_W = 15;
  localparam int DT_W    = 16;

  // State widths
  localparam int ACCUM_W = 32;
  localparam int DERIV_W = 32;

  // Shared multiplier: unsigned A operand, signed B operand
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;

  // Sum of the P, I and D terms
  localparam int SUM_W = 42;

  // Serial divider for the raw derivative: |delta error| * 2^16 / dt
  localparam int DIV_N_W   = 33;
  localparam int DIV_D_W   = DT_W;
  localparam int DIV_CNT_W = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic signed [ERR_W-1:0] PI_Q12     = 17'sd12868;
  localparam logic signed [ERR_W-1:0] TWO_PI_Q12 = 17'sd25736;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_DERIV_SMOOTH = 3'd3,
    REG_INTEG_LIMIT  = 3'd4,
    REG_DRIVE_LIMIT  = 3'd5,
    REG_WRAP_ENABLE  = 3'd6
  } cfg_reg_t;

endpackage

// ===== rtl/core/pid_axis_antiwindup_dfilter.sv =====
// PID axis with integral clamp and low-pass filtered derivative, fixed point.
// Depends on pidaw_pkg and pidaw_div.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | sink      | in_valid / in_stall | action, target_angle, measured_angle,
//          |           |                     | step_time
//  out     | source    | out_valid/out_stall | drive
//  cfg     | sink      | cfg_write           | cfg_index, cfg_data
//
// A control update runs from one input transfer to the next (error wrapping adds
// at most three wrap steps); the serial divide of the error change by step_time
// dominates, the rest is one step per cycle through the single shared multiplier,
// except that the last step waits while the output register is still held.
// A clear request or a zero step_time goes straight to the saturation state,
// which posts its zero drive. The result sits in an output register, so the next
// item can be taken while it waits. Reset (rst, synchronous) restores register
// defaults and zero state.
module pid_axis_antiwindup_dfilter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   action,
  input  logic signed [pidaw_pkg::ANGLE_W-1:0]   target_angle,
  input  logic signed [pidaw_pkg::ANGLE_W-1:0]   measured_angle,
  input  logic [pidaw_pkg::DT_W-1:0]             step_time,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pidaw_pkg::ANGLE_W-1:0]   drive
);
  import pidaw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_MP, S_MI, S_ACC, S_MIG, S_DIVST, S_DIV,
    S_MF, S_FILT, S_MD, S_DSH, S_SAT
  } state_t;

  state_t state;

  // Configuration registers
  logic [GAIN_W-1:0]   prop_gain;
  logic [GAIN_W-1:0]   integ_gain;
  logic [GAIN_W-1:0]   deriv_gain;
  logic [SMOOTH_W-1:0] deriv_smooth;
  logic [LIMIT_W-1:0]  integ_limit;
  logic [LIMIT_W-1:0]  drive_limit;
  logic                wrap_enable;

  // Controller state
  logic signed [ACCUM_W-1:0] integ_accum;
  logic signed [ERR_W-1:0]   last_error;
  logic signed [DERIV_W-1:0] last_deriv;

  // Per-item working registers
  logic signed [ERR_W-1:0]   err;
  logic [DT_W-1:0]           dt;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   p_term;
  logic signed [SUM_W-1:0]   i_term;
  logic signed [SUM_W-1:0]   d_term;
  logic signed [SUM_W-1:0]   pi_sum;
  logic signed [DERIV_W-1:0] raw;

  logic in_xfer;
  logic out_free;
  logic post_result;

  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != S_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign post_result = (state == S_SAT) && out_free;

  // Shared multiplier operands
  logic [MUL_A_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [MUL_A_W-1:0]        smooth_a;

  assign smooth_a = deriv_smooth[SMOOTH_W-1] ? {1'b1, {(SMOOTH_W-1){1'b0}}} : deriv_smooth;

  always_comb begin
    unique case (state)
      S_MP: begin
        mul_a = {1'b0, prop_gain};
        mul_b = MUL_B_W'(err);
      end
      S_MI: begin
        mul_a = {1'b0, dt};
        mul_b = MUL_B_W'(err);
      end
      S_MIG: begin
        mul_a = {1'b0, integ_gain};
        mul_b = MUL_B_W'(integ_accum);
      end
      S_MF: begin
        mul_a = smooth_a;
        mul_b = MUL_B_W'(raw) - MUL_B_W'(last_deriv);
      end
      S_MD: begin
        mul_a = {1'b0, deriv_gain};
        mul_b = MUL_B_W'(last_deriv);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round to nearest, ties up: add half then arithmetic shift
  logic signed [PROD_W-1:0] prod_r8;
  logic signed [PROD_W-1:0] prod_r16;
  logic signed [PROD_W-1:0] prod_r24;

  assign prod_r8  = (prod + PROD_W'(128)) >>> 8;
  assign prod_r16 = (prod + PROD_W'(32768)) >>> 16;
  assign prod_r24 = (prod + PROD_W'(8388608)) >>> 24;

  // Integral update with clamp
  localparam int ACC_SUM_W = ACCUM_W + 3;
  logic signed [ACC_SUM_W-1:0] acc_sum;
  logic signed [ACC_SUM_W-1:0] acc_lim;
  logic signed [ACCUM_W-1:0]   acc_next;

  assign acc_sum = ACC_SUM_W'(integ_accum) + $signed(prod[ACC_SUM_W-1:0]);
  assign acc_lim = $signed({{(ACC_SUM_W-LIMIT_W-16){1'b0}}, integ_limit, 16'h0000});

  always_comb begin
    priority if (acc_sum > acc_lim) begin
      acc_next = ACCUM_W'(acc_lim);
    end else if (acc_sum < -acc_lim) begin
      acc_next = ACCUM_W'(-acc_lim);
    end else begin
      acc_next = ACCUM_W'(acc_sum);
    end
  end

  // Raw derivative from divider magnitude, sign restored, saturated
  logic signed [ERR_W:0]   err_diff;
  logic [ERR_W-1:0]        diff_mag;
  logic [DIV_N_W-1:0]      div_quo;
  logic                    div_done;
  logic [DERIV_W-1:0]      raw_mag;

  assign err_diff = ERR_W'(err) - ERR_W'(last_error) == 0 ? '0 :
                    (ERR_W+1)'(err) - (ERR_W+1)'(last_error);
  assign diff_mag = err_diff[ERR_W] ? ERR_W'(-err_diff) : err_diff[ERR_W-1:0];
  assign raw_mag  = (div_quo[DIV_N_W-1:DERIV_W-1] != '0) ? {1'b0, {(DERIV_W-1){1'b1}}}
                                                          : div_quo[DERIV_W-1:0];

  pidaw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIVST),
    .dividend ({diff_mag, 16'h0000}),
    .divisor  (dt),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Derivative filter: last + round(a * (raw - last) / 2^16), saturated
  localparam int FILT_W = DERIV_W + 4;
  localparam logic signed [FILT_W-1:0] DERIV_MAX = FILT_W'(64'sh7FFFFFFF);
  logic signed [FILT_W-1:0]  filt_sum;
  logic signed [DERIV_W-1:0] filt_next;

  assign filt_sum = FILT_W'(last_deriv) + $signed(prod_r16[FILT_W-1:0]);

  always_comb begin
    priority if (filt_sum > DERIV_MAX) begin
      filt_next = DERIV_W'(DERIV_MAX);
    end else if (filt_sum < -DERIV_MAX) begin
      filt_next = DERIV_W'(-DERIV_MAX);
    end else begin
      filt_next = DERIV_W'(filt_sum);
    end
  end

  // Output saturation
  logic signed [SUM_W-1:0]   drive_sum;
  logic signed [SUM_W-1:0]   drive_lim;
  logic signed [ANGLE_W-1:0] drive_next;

  assign drive_sum = pi_sum + d_term;
  assign drive_lim = $signed({{(SUM_W-LIMIT_W){1'b0}}, drive_limit});

  always_comb begin
    priority if (drive_sum > drive_lim) begin
      drive_next = ANGLE_W'(drive_lim);
    end else if (drive_sum < -drive_lim) begin
      drive_next = ANGLE_W'(-drive_lim);
    end else begin
      drive_next = ANGLE_W'(drive_sum);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= GAIN_W'(256);
      integ_gain   <= '0;
      deriv_gain   <= '0;
      deriv_smooth <= SMOOTH_W'(65536);
      integ_limit  <= {LIMIT_W{1'b1}};
      drive_limit  <= {LIMIT_W{1'b1}};
      wrap_enable  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PROP_GAIN:    prop_gain    <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:   integ_gain   <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:   deriv_gain   <= cfg_data[GAIN_W-1:0];
        REG_DERIV_SMOOTH: deriv_smooth <= cfg_data[SMOOTH_W-1:0];
        REG_INTEG_LIMIT:  integ_limit  <= cfg_data[LIMIT_W-1:0];
        REG_DRIVE_LIMIT:  drive_limit  <= cfg_data[LIMIT_W-1:0];
        REG_WRAP_ENABLE:  wrap_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, mul_a}) * mul_b;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      integ_accum <= '0;
      last_error  <= '0;
      last_deriv  <= '0;
    end else begin
      if (post_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (action) begin
              integ_accum <= '0;
              last_error  <= '0;
              last_deriv  <= '0;
              pi_sum      <= '0;
              d_term      <= '0;
              state       <= S_SAT;
            end else if (step_time == '0) begin
              pi_sum <= '0;
              d_term <= '0;
              state  <= S_SAT;
            end else begin
              err   <= ERR_W'(target_angle) - ERR_W'(measured_angle);
              dt    <= step_time;
              state <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          priority if (wrap_enable && err > PI_Q12) begin
            err <= err - TWO_PI_Q12;
          end else if (wrap_enable && err < -PI_Q12) begin
            err <= err + TWO_PI_Q12;
          end else begin
            state <= S_MP;
          end
        end
        S_MP: state <= S_MI;
        S_MI: begin
          p_term <= SUM_W'(prod_r8);
          state  <= S_ACC;
        end
        S_ACC: begin
          integ_accum <= acc_next;
          state       <= S_MIG;
        end
        S_MIG: state <= S_DIVST;
        S_DIVST: begin
          i_term <= SUM_W'(prod_r24);
          state  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            raw   <= err_diff[ERR_W] ? DERIV_W'(-$signed(raw_mag)) : $signed(raw_mag);
            state <= S_MF;
          end
        end
        S_MF: state <= S_FILT;
        S_FILT: begin
          last_deriv <= filt_next;
          last_error <= err;
          state      <= S_MD;
        end
        S_MD: begin
          pi_sum <= p_term + i_term;
          state  <= S_DSH;
        end
        S_DSH: begin
          d_term <= SUM_W'(prod_r8);
          state  <= S_SAT;
        end
        S_SAT: begin
          if (out_free) begin
            drive <= drive_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  a_wrapped_error: assert property (@(posedge clk) disable iff (rst)
    (state == S_MP && wrap_enable) |-> (err <= PI_Q12 && err >= -PI_Q12))
    else $error("error not wrapped into [-pi, pi]");

  a_deriv_saturated: assert property (@(posedge clk) disable iff (rst)
    state == S_FILT |=> last_deriv != {1'b1, {(DERIV_W-1){1'b0}}})
    else $error("filtered derivative outside saturation range");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (state == S_SAT && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished update did not post a result");

endmodule

// ===== rtl/core/pidaw_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on pidaw_pkg for operand widths.
module pidaw_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pidaw_pkg::DIV_N_W-1:0] dividend,
  input  logic [pidaw_pkg::DIV_D_W-1:0] divisor,
  output logic                          done,
  output logic [pidaw_pkg::DIV_N_W-1:0] quotient
);
  import pidaw_pkg::*;

  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dvs;
  logic [DIV_N_W-1:0]   quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;

  logic [DIV_D_W:0]   rem_sh;
  logic [DIV_D_W+1:0] trial;

  assign rem_sh   = {rem, quo[DIV_N_W-1]};
  assign trial    = {1'b0, rem_sh} - {2'b00, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_N_W);
        rem  <= '0;
        dvs  <= divisor;
        quo  <= dividend;
      end else if (busy) begin
        if (!trial[DIV_D_W+1]) begin
          rem <= trial[DIV_D_W-1:0];
        end else begin
          rem <= rem_sh[DIV_D_W-1:0];
        end
        quo <= {quo[DIV_N_W-2:0], ~trial[DIV_D_W+1]};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  dly_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

endmodule
